[sv/tce_pkg.sv]
// shared types, codes and constants of the text cursor engine
package tce_pkg;

   // tab stops sit on multiples of this width (power of two, so rounding is a mask)
   localparam int unsigned TAB_WIDTH = 8;

   localparam logic [7:0] RESET_COLUMNS = 8'd80;
   localparam logic [7:0] RESET_ROWS    = 8'd25;

   localparam logic [7:0] CH_TAB     = 8'd9;
   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_RETURN  = 8'd13;

   typedef enum logic [1:0] {
      ACT_PUT   = 2'd0,
      ACT_SET   = 2'd1,
      ACT_QUERY = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      EV_DRAW   = 2'd0,
      EV_SCROLL = 2'd1,
      EV_REPORT = 2'd2
   } event_type;

   typedef enum logic [0:0] {
      REG_SCREEN_COLUMNS = 1'b0,
      REG_SCREEN_ROWS    = 1'b1
   } reg_index_type;

   typedef struct packed {
      event_type   event_kind;
      logic [7:0]  glyph;
      logic [7:0]  at_column;
      logic [7:0]  at_row;
      logic [31:0] color_out;
      logic        last;
   } result_type;

endpackage

[sv/text_cursor_engine.sv]
// top level of the text cursor engine: cursor update, config registers, result queue
//
// channel | dir | handshake              | payload
// --------+-----+------------------------+--------------------------------------------
// req     | in  | req_tvalid/req_tready  | tuser: action; tdata: char, color, col, row
// rsp     | out | rsp_tvalid/rsp_tready  | tuser: event kind; tdata: glyph, col, row,
//         |     |                        | color; tlast: final result of the item
// csr     | in  | csr_valid/csr_ready    | csr_index, csr_data
//
// one item is accepted per cycle while the result queue holds at most one result;
// the cursor register and the result queue are both written at the end of the accept cycle
// an item gives zero, one or two results; the output port drains one per cycle while
// rsp_tready is high, so a stream of two-result items is throttled to that drain rate
// synchronous active-high reset: cursor at column 0 row 0, 80 columns, 25 rows
// the csr port is always ready; a write to a register has effect on the next item
module text_cursor_engine (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // char_code[7:0], glyph_color[39:8],
                                    // new_column[47:40], new_row[55:48]
   input  logic [1:0]  req_tuser,   // action[1:0]

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // glyph[7:0], at_column[15:8], at_row[23:16],
                                    // color_out[55:24]
   output logic [1:0]  rsp_tuser,   // event_kind[1:0]
   output logic        rsp_tlast,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_data
);

   // configuration registers
   logic [7:0] screen_columns_ff;
   logic [7:0] screen_rows_ff;

   // cursor
   logic [7:0] cursor_column_ff;
   logic [7:0] cursor_column_in;
   logic [7:0] cursor_row_ff;
   logic [7:0] cursor_row_in;

   // unpacked request fields
   logic [7:0]  char_code;
   logic [31:0] glyph_color;
   logic [7:0]  new_column;
   logic [7:0]  new_row;

   logic req_fire;

   // cursor arithmetic, 9 bits so column 255 plus one still compares right
   logic [7:0] bottom_row;
   logic [8:0] row_inc;
   logic [8:0] col_inc;
   logic       step_wrap;
   logic [8:0] step_row;
   logic [7:0] step_col;
   logic       step_scroll;
   logic       newline_scroll;
   logic [8:0] tab_sum;
   logic [8:0] tab_next;
   logic       tab_past_end;

   // results of the current transaction
   logic [1:0]          push_count;
   tce_pkg::result_type push_first;
   tce_pkg::result_type push_second;
   tce_pkg::result_type rsp_item;
   tce_pkg::result_type scroll_result;

   assign char_code   = req_tdata[7:0];
   assign glyph_color = req_tdata[39:8];
   assign new_column  = req_tdata[47:40];
   assign new_row     = req_tdata[55:48];

   assign req_fire  = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         screen_columns_ff <= tce_pkg::RESET_COLUMNS;
         screen_rows_ff    <= tce_pkg::RESET_ROWS;
      end else if (csr_valid && csr_ready) begin
         unique case (tce_pkg::reg_index_type'(csr_index))
            tce_pkg::REG_SCREEN_COLUMNS: screen_columns_ff <= csr_data;
            tce_pkg::REG_SCREEN_ROWS:    screen_rows_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // with zero rows the bottom row counts as row 0
   assign bottom_row     = (screen_rows_ff == 8'd0) ? 8'd0 : screen_rows_ff - 8'd1;
   assign row_inc        = {1'b0, cursor_row_ff} + 9'd1;
   assign col_inc        = {1'b0, cursor_column_ff} + 9'd1;
   assign newline_scroll = (row_inc >= {1'b0, screen_rows_ff});

   // single cursor step: advance, wrap at the line end, then check the row bound
   assign step_wrap   = (col_inc >= {1'b0, screen_columns_ff});
   assign step_row    = step_wrap ? row_inc : {1'b0, cursor_row_ff};
   assign step_col    = step_wrap ? 8'd0 : col_inc[7:0];
   assign step_scroll = (step_row >= {1'b0, screen_rows_ff});

   // next tab stop: round up past the current column
   assign tab_sum      = {1'b0, cursor_column_ff} + 9'(tce_pkg::TAB_WIDTH);
   assign tab_next     = tab_sum & ~9'(tce_pkg::TAB_WIDTH - 1);
   assign tab_past_end = (tab_next >= {1'b0, screen_columns_ff});

   always_comb begin
      scroll_result.event_kind = tce_pkg::EV_SCROLL;
      scroll_result.glyph      = 8'd0;
      scroll_result.at_column  = 8'd0;
      scroll_result.at_row     = bottom_row;
      scroll_result.color_out  = 32'd0;
      scroll_result.last       = 1'b1;
   end

   always_comb begin
      cursor_column_in = cursor_column_ff;
      cursor_row_in    = cursor_row_ff;
      push_count       = 2'd0;
      push_first       = scroll_result;
      push_second      = scroll_result;

      if (req_fire) begin
         unique case (req_tuser)
            tce_pkg::ACT_SET: begin
               cursor_column_in = new_column;
               cursor_row_in    = new_row;
            end
            tce_pkg::ACT_QUERY: begin
               push_count            = 2'd1;
               push_first.event_kind = tce_pkg::EV_REPORT;
               push_first.at_column  = cursor_column_ff;
               push_first.at_row     = cursor_row_ff;
            end
            tce_pkg::ACT_PUT: begin
               unique case (char_code)
                  tce_pkg::CH_NEWLINE: begin
                     cursor_column_in = 8'd0;
                     if (newline_scroll) begin
                        cursor_row_in = bottom_row;
                        push_count    = 2'd1;
                     end else begin
                        cursor_row_in = row_inc[7:0];
                     end
                  end
                  tce_pkg::CH_RETURN: begin
                     cursor_column_in = 8'd0;
                  end
                  tce_pkg::CH_TAB: begin
                     // a tab stops at its first wrap or scroll
                     if (step_scroll) begin
                        cursor_column_in = 8'd0;
                        cursor_row_in    = bottom_row;
                        push_count       = 2'd1;
                     end else if (step_wrap) begin
                        cursor_column_in = 8'd0;
                        cursor_row_in    = step_row[7:0];
                     end else if (tab_past_end) begin
                        cursor_column_in = 8'd0;
                        if (newline_scroll) begin
                           cursor_row_in = bottom_row;
                           push_count    = 2'd1;
                        end else begin
                           cursor_row_in = row_inc[7:0];
                        end
                     end else begin
                        cursor_column_in = tab_next[7:0];
                     end
                  end
                  default: begin
                     // draw at the cursor, then advance; a scroll follows the draw
                     push_first.event_kind = tce_pkg::EV_DRAW;
                     push_first.glyph      = char_code;
                     push_first.at_column  = cursor_column_ff;
                     push_first.at_row     = cursor_row_ff;
                     push_first.color_out  = glyph_color;
                     if (step_scroll) begin
                        cursor_column_in = 8'd0;
                        cursor_row_in    = bottom_row;
                        push_first.last  = 1'b0;
                        push_count       = 2'd2;
                     end else begin
                        cursor_column_in = step_col;
                        cursor_row_in    = step_row[7:0];
                        push_count       = 2'd1;
                     end
                  end
               endcase
            end
            default: ;  // unused action: no effect, no result
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_column_ff <= 8'd0;
         cursor_row_ff    <= 8'd0;
      end else begin
         cursor_column_ff <= cursor_column_in;
         cursor_row_ff    <= cursor_row_in;
      end
   end

   tce_result_queue u_result_queue (
      .clock       (clock),
      .reset       (reset),
      .push_count  (push_count),
      .push_first  (push_first),
      .push_second (push_second),
      .has_room    (req_tready),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_item    (rsp_item)
   );

   assign rsp_tuser = rsp_item.event_kind;
   assign rsp_tlast = rsp_item.last;
   assign rsp_tdata = {rsp_item.color_out, rsp_item.at_row, rsp_item.at_column,
                       rsp_item.glyph};

   // set position lands in the cursor on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser == tce_pkg::ACT_SET) |=>
         (cursor_column_ff == $past(new_column) && cursor_row_ff == $past(new_row)))
      else $error("set position not applied to cursor");

   // any transaction that yields a scroll leaves the cursor at column 0 of the bottom row
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser == tce_pkg::ACT_PUT && push_count != 2'd0 &&
       (push_first.event_kind == tce_pkg::EV_SCROLL || push_count == 2'd2)) |=>
         (cursor_column_ff == 8'd0 && cursor_row_ff == $past(bottom_row)))
      else $error("scroll left cursor off the bottom row start");

   // a query gives exactly one result, marked last, and moves nothing
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser == tce_pkg::ACT_QUERY) |->
         (push_count == 2'd1 && push_first.last &&
          cursor_column_in == cursor_column_ff && cursor_row_in == cursor_row_ff))
      else $error("query result malformed");

endmodule

[sv/tce_result_queue.sv]
// three-entry result queue that takes up to two results per transaction
module tce_result_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          push_count,
   input  tce_pkg::result_type push_first,
   input  tce_pkg::result_type push_second,
   output logic                has_room,
   output logic                out_valid,
   input  logic                out_ready,
   output tce_pkg::result_type out_item
);

   tce_pkg::result_type slot_ff [3];
   tce_pkg::result_type slot_in [3];
   logic [1:0]          count_ff;
   logic [1:0]          count_in;
   logic                pop;
   logic [1:0]          base;
   logic [1:0]          base_next;

   // room for two more results, so a new item never overflows
   assign has_room  = !count_ff[1];
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = slot_ff[0];
   assign pop       = out_valid && out_ready;
   assign base      = count_ff - {1'b0, pop};
   assign base_next = base + 2'd1;
   assign count_in  = base + push_count;

   always_comb begin
      // head shift on pop
      slot_in[0] = pop ? slot_ff[1] : slot_ff[0];
      slot_in[1] = pop ? slot_ff[2] : slot_ff[1];
      slot_in[2] = slot_ff[2];
      if (push_count != 2'd0) begin
         if (base == 2'd0) slot_in[0] = push_first;
         if (base == 2'd1) slot_in[1] = push_first;
         if (base == 2'd2) slot_in[2] = push_first;
      end
      if (push_count == 2'd2) begin
         if (base_next == 2'd1) slot_in[1] = push_second;
         if (base_next == 2'd2) slot_in[2] = push_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule
